// ===== sv/khop_pkg.sv =====
// Shared types and constants for the k-hop neighbor expansion block.
// Used by the adjacency table, the query engine and the top level.
// No dependencies.
`default_nettype none

package khop_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int NC_W        = NODE_W + 1;
   localparam int MAX_ENTRIES = 8192;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int EC_W        = ADDR_W + 1;
   localparam int MAX_ORDER   = 8;
   localparam int ORD_W       = $clog2(MAX_ORDER) + 1;
   localparam int MAX_LIST    = 64;
   localparam int CNT_W       = $clog2(MAX_LIST + 2);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = NC_W;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODE_COUNT = 2'd0,
      CSR_HOP_ORDER  = 2'd1,
      CSR_CUMULATIVE = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_idx_type;

   // Read port of the adjacency table as seen by the query engine.
   typedef struct packed {
      logic [NODE_W-1:0] le_addr;
      logic [ADDR_W-1:0] st_addr;
   } tbl_rd_req_type;

   typedef struct packed {
      logic [EC_W-1:0]   le_data;
      logic [NODE_W-1:0] st_data;
      logic [EC_W-1:0]   entry_count;
      logic [NODE_W-1:0] last_node;
   } tbl_rd_rsp_type;

endpackage

`default_nettype wire

// ===== sv/khop_table.sv =====
// Adjacency table: list end pointers and the neighbor store, with load and clear.
// Depends on khop_pkg.
`default_nettype none

module khop_table (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         ld_start,
   input  wire logic                         clr_start,
   input  wire logic [khop_pkg::NODE_W-1:0]  ld_owner,
   input  wire logic [khop_pkg::NODE_W-1:0]  ld_neighbor,
   input  wire khop_pkg::tbl_rd_req_type     rd_req,
   output khop_pkg::tbl_rd_rsp_type          rd_rsp,
   output logic                              busy
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_COMMIT
   } state_type;

   state_type                       state_ff, state_in;
   logic [khop_pkg::EC_W-1:0]       ec_ff, ec_in;
   logic [khop_pkg::NODE_W-1:0]     last_ff, last_in;
   logic [khop_pkg::NODE_W-1:0]     own_ff, own_in;
   logic [khop_pkg::NODE_W-1:0]     nb_ff, nb_in;
   logic [khop_pkg::NC_W-1:0]       fill_ff, fill_in;
   logic [khop_pkg::NC_W-1:0]       fill_start;

   logic [khop_pkg::EC_W-1:0]       le_mem [khop_pkg::MAX_NODES];
   logic [khop_pkg::NODE_W-1:0]     st_mem [khop_pkg::MAX_ENTRIES];
   logic [khop_pkg::EC_W-1:0]       le_rd_ff;
   logic [khop_pkg::NODE_W-1:0]     st_rd_ff;

   logic                            le_we;
   logic [khop_pkg::NODE_W-1:0]     le_waddr;
   logic [khop_pkg::EC_W-1:0]       le_wdata;
   logic                            st_we;

   assign fill_start = (ec_ff == '0) ? '0 : ({1'b0, last_ff} + khop_pkg::NC_W'(1));

   always_comb begin
      state_in = state_ff;
      ec_in    = ec_ff;
      last_in  = last_ff;
      own_in   = own_ff;
      nb_in    = nb_ff;
      fill_in  = fill_ff;
      le_we    = 1'b0;
      le_waddr = fill_ff[khop_pkg::NODE_W-1:0];
      le_wdata = ec_ff;
      st_we    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (clr_start) begin
               ec_in   = '0;
               last_in = '0;
            end else if (ld_start) begin
               // A full table or a descending owner drops the entry.
               if (ec_ff != khop_pkg::EC_W'(khop_pkg::MAX_ENTRIES) &&
                   !(ec_ff != '0 && ld_owner < last_ff)) begin
                  own_in  = ld_owner;
                  nb_in   = ld_neighbor;
                  fill_in = fill_start;
                  if (fill_start < {1'b0, ld_owner}) begin
                     state_in = ST_FILL;
                  end else begin
                     state_in = ST_COMMIT;
                  end
               end
            end
         end
         ST_FILL: begin
            // Skipped owners get empty lists ending at the current count.
            le_we   = 1'b1;
            fill_in = fill_ff + khop_pkg::NC_W'(1);
            if (fill_ff + khop_pkg::NC_W'(1) == {1'b0, own_ff}) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            le_we    = 1'b1;
            le_waddr = own_ff;
            le_wdata = ec_ff + khop_pkg::EC_W'(1);
            st_we    = 1'b1;
            ec_in    = ec_ff + khop_pkg::EC_W'(1);
            last_in  = own_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ec_ff    <= '0;
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ec_ff    <= ec_in;
         last_ff  <= last_in;
      end
      own_ff  <= own_in;
      nb_ff   <= nb_in;
      fill_ff <= fill_in;
   end

   always_ff @(posedge clock) begin
      if (le_we) begin
         le_mem[le_waddr] <= le_wdata;
      end
      le_rd_ff <= le_mem[rd_req.le_addr];
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[ec_ff[khop_pkg::ADDR_W-1:0]] <= nb_ff;
      end
      st_rd_ff <= st_mem[rd_req.st_addr];
   end

   assign rd_rsp.le_data     = le_rd_ff;
   assign rd_rsp.st_data     = st_rd_ff;
   assign rd_rsp.entry_count = ec_ff;
   assign rd_rsp.last_node   = last_ff;
   assign busy               = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/khop_engine.sv =====
// Query engine: a sequencer that walks frontiers over a per-node bitmap memory
// and emits the answer. Depends on khop_pkg and reads khop_table through rd_req and rd_rsp.
`default_nettype none

module khop_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_start,
   input  wire logic [khop_pkg::NODE_W-1:0]  q_node,
   input  wire logic [khop_pkg::NC_W-1:0]    nc_eff,
   input  wire logic [khop_pkg::ORD_W-1:0]   k_eff,
   input  wire logic                         cum,
   output khop_pkg::tbl_rd_req_type          rd_req,
   input  wire khop_pkg::tbl_rd_rsp_type     rd_rsp,
   output logic                              busy,
   output logic                              rsp_strobe,
   output logic                              rsp_valid_res,
   output logic [khop_pkg::NODE_W-1:0]       rsp_neighbor_node_out,
   output logic                              rsp_last,
   output logic                              rsp_truncated
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_INIT, ST_RNG_A, ST_RNG_B, ST_RNG_C,
      ST_EW_A, ST_EW_B, ST_EW_C, ST_LV_DONE, ST_CLR_A, ST_CLR_B,
      ST_SC_A, ST_SC_B, ST_CN_A, ST_CN_B, ST_EM_A, ST_EM_B,
      ST_K1_START, ST_K1_A, ST_K1_B, ST_EMPTY
   } state_type;

   // Bit 3 of a bitmap word is the cumulative answer; bits 0 to 2 hold three
   // frontiers whose roles rotate from one level to the next.
   localparam logic [1:0] SLOT_ANSWER = 2'd3;
   localparam logic [1:0] SLOT_ZERO   = 2'd0;
   localparam logic [1:0] SLOT_ONE    = 2'd1;
   localparam logic [1:0] SLOT_TWO    = 2'd2;

   state_type                       state_ff, state_in, ret_ff, ret_in;
   logic [khop_pkg::NODE_W-1:0]     q_ff, q_in, n_ff, n_in, v_ff, v_in;
   logic [khop_pkg::NC_W-1:0]       u_ff, u_in, nc_ff, nc_in;
   logic [khop_pkg::EC_W-1:0]       i_ff, i_in, s_ff, s_in, e_ff, e_in, total_ff, total_in;
   logic [khop_pkg::ORD_W-1:0]      lvl_ff, lvl_in, k_ff, k_in;
   logic                            cum_ff, cum_in;
   logic [1:0]                      old_ff, old_in, pri_ff, pri_in, new_ff, new_in;
   logic [khop_pkg::CNT_W-1:0]      cnt_ff, cnt_in, r_ff, r_in;
   logic                            strobe_ff, strobe_in, valid_ff, valid_in;
   logic                            last_ff, last_in, trunc_ff, trunc_in;
   logic [khop_pkg::NODE_W-1:0]     node_ff, node_in;

   logic [3:0]                      bm_mem [khop_pkg::MAX_NODES];
   logic [3:0]                      bm_rd_ff;
   logic                            bm_we;
   logic [khop_pkg::NODE_W-1:0]     bm_waddr, bm_raddr;
   logic [3:0]                      bm_wdata;

   logic [khop_pkg::EC_W-1:0]       rng_e, rng_s;
   logic [1:0]                      ans_sel;
   logic                            is_last;

   assign ans_sel = cum_ff ? SLOT_ANSWER : new_ff;
   assign is_last = (r_ff + khop_pkg::CNT_W'(1) == cnt_ff);

   always_comb begin
      rng_e = (rd_rsp.le_data > rd_rsp.entry_count) ? rd_rsp.entry_count : rd_rsp.le_data;
      rng_s = (s_ff > rng_e) ? rng_e : s_ff;
      if (rd_rsp.entry_count == '0 || n_ff > rd_rsp.last_node) begin
         rng_e = '0;
         rng_s = '0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      q_in      = q_ff;
      n_in      = n_ff;
      v_in      = v_ff;
      u_in      = u_ff;
      nc_in     = nc_ff;
      i_in      = i_ff;
      s_in      = s_ff;
      e_in      = e_ff;
      total_in  = total_ff;
      lvl_in    = lvl_ff;
      k_in      = k_ff;
      cum_in    = cum_ff;
      old_in    = old_ff;
      pri_in    = pri_ff;
      new_in    = new_ff;
      cnt_in    = cnt_ff;
      r_in      = r_ff;
      strobe_in = 1'b0;
      valid_in  = 1'b0;
      node_in   = '0;
      last_in   = 1'b0;
      trunc_in  = 1'b0;
      bm_we     = 1'b0;
      bm_waddr  = v_ff;
      bm_wdata  = '0;
      bm_raddr  = u_ff[khop_pkg::NODE_W-1:0];
      rd_req.le_addr = n_ff;
      rd_req.st_addr = i_ff[khop_pkg::ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (q_start) begin
               q_in     = q_node;
               nc_in    = nc_eff;
               k_in     = k_eff;
               cum_in   = cum;
               r_in     = '0;
               total_in = '0;
               u_in     = '0;
               if ({1'b0, q_node} >= nc_eff) begin
                  state_in = ST_EMPTY;
               end else if (k_eff == khop_pkg::ORD_W'(1)) begin
                  n_in     = q_node;
                  ret_in   = ST_K1_START;
                  state_in = ST_RNG_A;
               end else begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            if (u_ff == nc_ff) begin
               n_in     = q_ff;
               ret_in   = ST_EW_A;
               lvl_in   = khop_pkg::ORD_W'(1);
               old_in   = SLOT_TWO;
               pri_in   = SLOT_ZERO;
               new_in   = SLOT_ONE;
               state_in = ST_RNG_A;
            end else begin
               bm_we    = 1'b1;
               bm_waddr = u_ff[khop_pkg::NODE_W-1:0];
               bm_wdata = (u_ff[khop_pkg::NODE_W-1:0] == q_ff) ? 4'b0001 : 4'b0000;
               u_in     = u_ff + khop_pkg::NC_W'(1);
            end
         end
         ST_RNG_A: begin
            rd_req.le_addr = n_ff - khop_pkg::NODE_W'(1);
            state_in = ST_RNG_B;
         end
         ST_RNG_B: begin
            s_in     = (n_ff == '0) ? '0 : rd_rsp.le_data;
            state_in = ST_RNG_C;
         end
         ST_RNG_C: begin
            i_in     = rng_s;
            e_in     = rng_e;
            state_in = ret_ff;
         end
         ST_EW_A: begin
            if (i_ff == e_ff) begin
               if (lvl_ff == khop_pkg::ORD_W'(1)) begin
                  state_in = ST_LV_DONE;
               end else begin
                  u_in     = u_ff + khop_pkg::NC_W'(1);
                  state_in = ST_SC_A;
               end
            end else begin
               state_in = ST_EW_B;
            end
         end
         ST_EW_B: begin
            if ({1'b0, rd_rsp.st_data} >= nc_ff) begin
               i_in     = i_ff + khop_pkg::EC_W'(1);
               state_in = ST_EW_A;
            end else begin
               bm_raddr = rd_rsp.st_data;
               v_in     = rd_rsp.st_data;
               state_in = ST_EW_C;
            end
         end
         ST_EW_C: begin
            if (lvl_ff == khop_pkg::ORD_W'(1) || (!bm_rd_ff[pri_ff] && !bm_rd_ff[old_ff])) begin
               bm_we    = 1'b1;
               bm_wdata = bm_rd_ff | (4'b0001 << new_ff) | (cum_ff ? 4'b1000 : 4'b0000);
            end
            i_in     = i_ff + khop_pkg::EC_W'(1);
            state_in = ST_EW_A;
         end
         ST_LV_DONE: begin
            if (lvl_ff == k_ff) begin
               u_in     = nc_ff;
               total_in = '0;
               state_in = ST_CN_A;
            end else begin
               lvl_in   = lvl_ff + khop_pkg::ORD_W'(1);
               old_in   = pri_ff;
               pri_in   = new_ff;
               new_in   = old_ff;
               u_in     = '0;
               state_in = ST_CLR_A;
            end
         end
         ST_CLR_A: begin
            if (u_ff == nc_ff) begin
               u_in     = '0;
               state_in = ST_SC_A;
            end else begin
               state_in = ST_CLR_B;
            end
         end
         ST_CLR_B: begin
            bm_we    = 1'b1;
            bm_waddr = u_ff[khop_pkg::NODE_W-1:0];
            bm_wdata = bm_rd_ff & ~(4'b0001 << new_ff);
            u_in     = u_ff + khop_pkg::NC_W'(1);
            state_in = ST_CLR_A;
         end
         ST_SC_A: begin
            if (u_ff == nc_ff) begin
               state_in = ST_LV_DONE;
            end else begin
               state_in = ST_SC_B;
            end
         end
         ST_SC_B: begin
            if (bm_rd_ff[pri_ff]) begin
               n_in     = u_ff[khop_pkg::NODE_W-1:0];
               ret_in   = ST_EW_A;
               state_in = ST_RNG_A;
            end else begin
               u_in     = u_ff + khop_pkg::NC_W'(1);
               state_in = ST_SC_A;
            end
         end
         ST_CN_A: begin
            bm_raddr = u_ff[khop_pkg::NODE_W-1:0] - khop_pkg::NODE_W'(1);
            if (u_ff == '0) begin
               if (total_ff == '0) begin
                  state_in = ST_EMPTY;
               end else begin
                  cnt_in   = (total_ff > khop_pkg::EC_W'(khop_pkg::MAX_LIST)) ?
                             khop_pkg::CNT_W'(khop_pkg::MAX_LIST) :
                             total_ff[khop_pkg::CNT_W-1:0];
                  u_in     = nc_ff;
                  r_in     = '0;
                  state_in = ST_EM_A;
               end
            end else begin
               state_in = ST_CN_B;
            end
         end
         ST_CN_B: begin
            // The count saturates just above the cap; that is enough for the flag.
            if (bm_rd_ff[ans_sel] && total_ff != khop_pkg::EC_W'(khop_pkg::MAX_LIST + 1)) begin
               total_in = total_ff + khop_pkg::EC_W'(1);
            end
            u_in     = u_ff - khop_pkg::NC_W'(1);
            state_in = ST_CN_A;
         end
         ST_EM_A: begin
            bm_raddr = u_ff[khop_pkg::NODE_W-1:0] - khop_pkg::NODE_W'(1);
            state_in = ST_EM_B;
         end
         ST_EM_B: begin
            u_in     = u_ff - khop_pkg::NC_W'(1);
            state_in = ST_EM_A;
            if (bm_rd_ff[ans_sel]) begin
               strobe_in = 1'b1;
               valid_in  = 1'b1;
               node_in   = u_ff[khop_pkg::NODE_W-1:0] - khop_pkg::NODE_W'(1);
               last_in   = is_last;
               trunc_in  = is_last && (total_ff > khop_pkg::EC_W'(khop_pkg::MAX_LIST));
               r_in      = r_ff + khop_pkg::CNT_W'(1);
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_K1_START: begin
            total_in = e_ff - i_ff;
            cnt_in   = ((e_ff - i_ff) > khop_pkg::EC_W'(khop_pkg::MAX_LIST)) ?
                       khop_pkg::CNT_W'(khop_pkg::MAX_LIST) :
                       khop_pkg::CNT_W'(e_ff - i_ff);
            r_in     = '0;
            state_in = (e_ff == i_ff) ? ST_EMPTY : ST_K1_A;
         end
         ST_K1_A: begin
            state_in = ST_K1_B;
         end
         ST_K1_B: begin
            strobe_in = 1'b1;
            valid_in  = 1'b1;
            node_in   = rd_rsp.st_data;
            last_in   = is_last;
            trunc_in  = is_last && (total_ff > khop_pkg::EC_W'(khop_pkg::MAX_LIST));
            i_in      = i_ff + khop_pkg::EC_W'(1);
            r_in      = r_ff + khop_pkg::CNT_W'(1);
            state_in  = is_last ? ST_IDLE : ST_K1_A;
         end
         ST_EMPTY: begin
            strobe_in = 1'b1;
            last_in   = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      ret_ff   <= ret_in;
      q_ff     <= q_in;
      n_ff     <= n_in;
      v_ff     <= v_in;
      u_ff     <= u_in;
      nc_ff    <= nc_in;
      i_ff     <= i_in;
      s_ff     <= s_in;
      e_ff     <= e_in;
      total_ff <= total_in;
      lvl_ff   <= lvl_in;
      k_ff     <= k_in;
      cum_ff   <= cum_in;
      old_ff   <= old_in;
      pri_ff   <= pri_in;
      new_ff   <= new_in;
      cnt_ff   <= cnt_in;
      r_ff     <= r_in;
      valid_ff <= valid_in;
      node_ff  <= node_in;
      last_ff  <= last_in;
      trunc_ff <= trunc_in;
   end

   always_ff @(posedge clock) begin
      if (bm_we) begin
         bm_mem[bm_waddr] <= bm_wdata;
      end
      bm_rd_ff <= bm_mem[bm_raddr];
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_strobe            = strobe_ff;
   assign rsp_valid_res         = valid_ff;
   assign rsp_neighbor_node_out = node_ff;
   assign rsp_last              = last_ff;
   assign rsp_truncated         = trunc_ff;

endmodule

`default_nettype wire

// ===== sv/k_hop_neighbor_expansion.sv =====
// Top level of the k-hop neighbor expansion block: configuration registers,
// request dispatch, and the khop_table and khop_engine instances. Uses khop_pkg.
//
// Usage: a request (req_cmd, req_owner_node, req_neighbor_node) is taken at a
// rising edge where start is high and busy is low. A load request appends one
// adjacency entry unless the table is full or the owner descends, and keeps
// busy high while it writes empty lists for skipped owners and commits the
// entry. A clear request empties the table in the accepting cycle. A query
// request walks the frontiers one memory access at a time over a per-node
// bitmap memory: it initializes the bitmap and walks the queried node's edge
// list, then per extra level clears a frontier and scans it, walking the edge
// list of each frontier node, then counts and emits. An order one query emits
// the queried node's list. Only one request is in progress at a time.
// The final result of a query is on the ports in the first cycle after busy
// falls, so the next request may be taken while it is out. Results appear on
// the rsp_ ports for one cycle each, marked by rsp_strobe; the receiver cannot
// stall them. Configuration writes on the csr_ channel are always ready and are
// to be issued only while idle.
// A synchronous reset empties the table and restores the default registers.
`default_nettype none

module k_hop_neighbor_expansion (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_cmd,
   input  wire logic [khop_pkg::NODE_W-1:0]      req_owner_node,
   input  wire logic [khop_pkg::NODE_W-1:0]      req_neighbor_node,
   output logic                                  rsp_strobe,
   output logic                                  rsp_valid_res,
   output logic [khop_pkg::NODE_W-1:0]           rsp_neighbor_node_out,
   output logic                                  rsp_last,
   output logic                                  rsp_truncated,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [khop_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [khop_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [khop_pkg::NC_W-1:0]    node_count_ff;
   logic [khop_pkg::ORD_W-1:0]   hop_order_ff;
   logic                         cumulative_ff;
   logic [khop_pkg::NC_W-1:0]    nc_eff;
   logic [khop_pkg::ORD_W-1:0]   k_eff;
   logic                         accept;
   logic                         tbl_busy, eng_busy;
   khop_pkg::cmd_type            cmd;
   khop_pkg::csr_idx_type        csr_idx;
   khop_pkg::tbl_rd_req_type     rd_req;
   khop_pkg::tbl_rd_rsp_type     rd_rsp;

   assign csr_ready = 1'b1;
   assign csr_idx   = khop_pkg::csr_idx_type'(csr_index);
   assign cmd       = khop_pkg::cmd_type'(req_cmd);
   assign busy      = tbl_busy | eng_busy;
   assign accept    = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= khop_pkg::NC_W'(1);
         hop_order_ff  <= khop_pkg::ORD_W'(2);
         cumulative_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_idx)
            khop_pkg::CSR_NODE_COUNT: begin
               node_count_ff <= csr_wdata[khop_pkg::NC_W-1:0];
            end
            khop_pkg::CSR_HOP_ORDER: begin
               hop_order_ff <= csr_wdata[khop_pkg::ORD_W-1:0];
            end
            khop_pkg::CSR_CUMULATIVE: begin
               cumulative_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      nc_eff = (node_count_ff > khop_pkg::NC_W'(khop_pkg::MAX_NODES)) ?
               khop_pkg::NC_W'(khop_pkg::MAX_NODES) : node_count_ff;
      if (hop_order_ff == '0) begin
         k_eff = khop_pkg::ORD_W'(1);
      end else if (hop_order_ff > khop_pkg::ORD_W'(khop_pkg::MAX_ORDER)) begin
         k_eff = khop_pkg::ORD_W'(khop_pkg::MAX_ORDER);
      end else begin
         k_eff = hop_order_ff;
      end
   end

   khop_table u_table (
      .clock       (clock),
      .reset       (reset),
      .ld_start    (accept && cmd == khop_pkg::CMD_LOAD),
      .clr_start   (accept && cmd == khop_pkg::CMD_CLEAR),
      .ld_owner    (req_owner_node),
      .ld_neighbor (req_neighbor_node),
      .rd_req      (rd_req),
      .rd_rsp      (rd_rsp),
      .busy        (tbl_busy)
   );

   khop_engine u_engine (
      .clock                 (clock),
      .reset                 (reset),
      .q_start               (accept && cmd == khop_pkg::CMD_QUERY),
      .q_node                (req_owner_node),
      .nc_eff                (nc_eff),
      .k_eff                 (k_eff),
      .cum                   (cumulative_ff),
      .rd_req                (rd_req),
      .rd_rsp                (rd_rsp),
      .busy                  (eng_busy),
      .rsp_strobe            (rsp_strobe),
      .rsp_valid_res         (rsp_valid_res),
      .rsp_neighbor_node_out (rsp_neighbor_node_out),
      .rsp_last              (rsp_last),
      .rsp_truncated         (rsp_truncated)
   );

endmodule

`default_nettype wire

// ===== sv/khop_checker.sv =====
// Port-level checks for k_hop_neighbor_expansion, attached by bind.
// Depends on khop_pkg and the top level's ports.
`default_nettype none

module khop_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         busy,
   input  wire logic [1:0]                   req_cmd,
   input  wire logic                         rsp_strobe,
   input  wire logic                         rsp_valid_res,
   input  wire logic [khop_pkg::NODE_W-1:0]  rsp_neighbor_node_out,
   input  wire logic                         rsp_last,
   input  wire logic                         rsp_truncated
);

   // A truncated answer flags it on its final item only.
   a_trunc_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_truncated |-> rsp_last)
      else $error("truncated set on an item that is not last");

   // An invalid item is only ever the single item of an empty answer.
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_valid_res |-> rsp_last && !rsp_truncated &&
                                       rsp_neighbor_node_out == '0)
      else $error("malformed empty answer");

   // An accepted query request raises busy, which stays high until its answer goes out.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cmd == khop_pkg::CMD_QUERY |=> busy)
      else $error("query accepted but block not busy");

   // Results come only out of work in progress.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a request in progress");

   // The final item closes the answer.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("result follows the last item directly");

endmodule

bind k_hop_neighbor_expansion khop_checker u_khop_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .req_cmd               (req_cmd),
   .rsp_strobe            (rsp_strobe),
   .rsp_valid_res         (rsp_valid_res),
   .rsp_neighbor_node_out (rsp_neighbor_node_out),
   .rsp_last              (rsp_last),
   .rsp_truncated         (rsp_truncated)
);

`default_nettype wire
